[rtl/assert_macros.svh]
// Assertion macros used by the checker file of the RRE decoder.
// Each macro expects signals clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define RRE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define RRE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rre_pkg.sv]
// Shared types and constants for the RRE rectangle decoder.
// No dependencies; used by every module of the block but the checker.
package rre_pkg;

  localparam int BYTE_W  = 8;
  localparam int FIELD_W = 16;
  localparam int COORD_W = 17;
  localparam int PIX_W   = 32;
  localparam int COUNT_W = 32;
  localparam int PSZ_W   = 2;
  localparam int CFG_IDX_W = 3;
  localparam int OUT_DATA_W = 104;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PSIZE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_W = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_H = 3'd4;

  // Pixel size codes; any other code means 4-byte pixels
  localparam logic [PSZ_W-1:0] PSZ_1B    = 2'd0;
  localparam logic [PSZ_W-1:0] PSZ_2B    = 2'd1;
  localparam logic [PSZ_W-1:0] PSZ_RESET = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE, PH_COUNT, PH_BG, PH_SPIX, PH_SX, PH_SY, PH_SW, PH_SH
  } phase_t;

  typedef enum logic [1:0] {
    CMD_BG, CMD_SUB, CMD_ERR
  } cmd_kind_t;

  typedef struct packed {
    logic [PSZ_W-1:0]   psize;
    logic [FIELD_W-1:0] rect_x;
    logic [FIELD_W-1:0] rect_y;
    logic [FIELD_W-1:0] rect_w;
    logic [FIELD_W-1:0] rect_h;
  } cfg_t;

  // Classified fill command handed from the parser to the back end
  typedef struct packed {
    cmd_kind_t          kind;
    logic [PIX_W-1:0]   pix;
    logic [FIELD_W-1:0] sx;
    logic [FIELD_W-1:0] sy;
    logic [FIELD_W-1:0] sw;
    logic [FIELD_W-1:0] sh;
    logic               last;
  } cmd_t;

  // Queue status seen by the back end and the input handshake
  typedef struct packed {
    logic full;
    logic nonempty;
  } q_stat_t;

  typedef struct packed {
    logic [COORD_W-1:0] xl;
    logic [COORD_W-1:0] yt;
    logic [COORD_W-1:0] xr;
    logic [COORD_W-1:0] yb;
    logic [PIX_W-1:0]   pix;
    logic               err;
    logic               last;
  } res_t;

endpackage

[rtl/rre_front.sv]
// Byte parser of the RRE decoder: walks the payload and classifies fill commands.
// Depends on rre_pkg.
module rre_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_accept,
  input  logic [rre_pkg::BYTE_W-1:0]  in_byte,
  input  logic                        in_start,
  input  rre_pkg::cfg_t               cfg,
  output logic                        push,
  output rre_pkg::cmd_t               cmd
);

  rre_pkg::phase_t              phase_r, phase_nxt, cur_phase;
  logic [1:0]                   idx_r, idx_nxt, cur_idx;
  logic [rre_pkg::COUNT_W-1:0]  left_r, left_nxt, cur_left, cnt_shift, dec_left;
  logic [rre_pkg::PIX_W-1:0]    pix_r, pix_nxt, cur_pix, pix_ins;
  logic [rre_pkg::BYTE_W-1:0]   fld_r, fld_nxt;
  logic [rre_pkg::FIELD_W-1:0]  sx_r, sx_nxt, sy_r, sy_nxt, sw_r, sw_nxt, fld_h;
  logic [2:0]                   nbytes;
  logic                         pix_more, x_over, y_over, last_w;

  // A start mark clears the parser and takes this byte as the first count byte
  assign cur_phase = in_start ? rre_pkg::PH_COUNT : phase_r;
  assign cur_idx   = in_start ? 2'd0 : idx_r;
  assign cur_left  = in_start ? '0 : left_r;
  assign cur_pix   = in_start ? '0 : pix_r;

  always_comb begin
    case (cfg.psize)
      rre_pkg::PSZ_1B: nbytes = 3'd1;
      rre_pkg::PSZ_2B: nbytes = 3'd2;
      default:         nbytes = 3'd4;
    endcase
  end

  assign pix_ins   = cur_pix | ({24'd0, in_byte} << {cur_idx, 3'b000});
  assign pix_more  = ({1'b0, cur_idx} + 3'd1) < nbytes;
  assign cnt_shift = {cur_left[23:0], in_byte};
  assign dec_left  = cur_left - 32'd1;
  assign fld_h     = {fld_r, in_byte};
  assign x_over    = ({1'b0, sx_r} + {1'b0, sw_r}) > {1'b0, cfg.rect_w};
  assign y_over    = ({1'b0, sy_r} + {1'b0, fld_h}) > {1'b0, cfg.rect_h};

  // Next parser state and the command a completed field produces
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    left_nxt  = left_r;
    pix_nxt   = pix_r;
    fld_nxt   = fld_r;
    sx_nxt    = sx_r;
    sy_nxt    = sy_r;
    sw_nxt    = sw_r;
    last_w    = 1'b0;
    push      = 1'b0;
    cmd.kind  = rre_pkg::CMD_BG;
    cmd.pix   = pix_ins;
    cmd.sx    = sx_r;
    cmd.sy    = sy_r;
    cmd.sw    = sw_r;
    cmd.sh    = fld_h;
    cmd.last  = 1'b0;
    if (in_accept) begin
      phase_nxt = cur_phase;
      idx_nxt   = cur_idx;
      left_nxt  = cur_left;
      pix_nxt   = cur_pix;
      case (cur_phase)
        rre_pkg::PH_COUNT: begin
          left_nxt = cnt_shift;
          if (cur_idx == 2'd3) begin
            // a count with the sign bit set means no subrectangles
            if (cnt_shift[rre_pkg::COUNT_W-1]) left_nxt = '0;
            idx_nxt   = 2'd0;
            phase_nxt = rre_pkg::PH_BG;
          end else begin
            idx_nxt = cur_idx + 2'd1;
          end
        end
        rre_pkg::PH_BG, rre_pkg::PH_SPIX: begin
          if (pix_more) begin
            pix_nxt = pix_ins;
            idx_nxt = cur_idx + 2'd1;
          end else begin
            idx_nxt = 2'd0;
            if (cur_phase == rre_pkg::PH_SPIX) begin
              pix_nxt   = pix_ins;
              phase_nxt = rre_pkg::PH_SX;
            end else begin
              last_w    = (cur_left == '0);
              push      = 1'b1;
              cmd.kind  = rre_pkg::CMD_BG;
              cmd.last  = last_w;
              pix_nxt   = '0;
              phase_nxt = last_w ? rre_pkg::PH_IDLE : rre_pkg::PH_SPIX;
            end
          end
        end
        rre_pkg::PH_SX, rre_pkg::PH_SY, rre_pkg::PH_SW, rre_pkg::PH_SH: begin
          if (cur_idx == 2'd0) begin
            fld_nxt = in_byte;
            idx_nxt = 2'd1;
          end else begin
            idx_nxt = 2'd0;
            if (cur_phase == rre_pkg::PH_SX) begin
              sx_nxt    = fld_h;
              phase_nxt = rre_pkg::PH_SY;
            end else if (cur_phase == rre_pkg::PH_SY) begin
              sy_nxt    = fld_h;
              phase_nxt = rre_pkg::PH_SW;
            end else if (cur_phase == rre_pkg::PH_SW) begin
              sw_nxt    = fld_h;
              phase_nxt = rre_pkg::PH_SH;
            end else begin
              push    = 1'b1;
              cmd.pix = cur_pix;
              pix_nxt = '0;
              if (x_over || y_over) begin
                // out of bounds: report and drop the rest of the rectangle
                cmd.kind  = rre_pkg::CMD_ERR;
                cmd.last  = 1'b1;
                left_nxt  = '0;
                phase_nxt = rre_pkg::PH_IDLE;
              end else begin
                last_w    = (dec_left == '0);
                cmd.kind  = rre_pkg::CMD_SUB;
                cmd.last  = last_w;
                left_nxt  = dec_left;
                phase_nxt = last_w ? rre_pkg::PH_IDLE : rre_pkg::PH_SPIX;
              end
            end
          end
        end
        default: begin
          // idle: ignore bytes until the next start mark
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rre_pkg::PH_IDLE;
      idx_r   <= '0;
      left_r  <= '0;
      pix_r   <= '0;
      fld_r   <= '0;
      sx_r    <= '0;
      sy_r    <= '0;
      sw_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      left_r  <= left_nxt;
      pix_r   <= pix_nxt;
      fld_r   <= fld_nxt;
      sx_r    <= sx_nxt;
      sy_r    <= sy_nxt;
      sw_r    <= sw_nxt;
    end
  end

endmodule

[rtl/rre_queue.sv]
// Two-entry command queue between the RRE parser and the result stage.
// Depends on rre_pkg.
module rre_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rre_pkg::cmd_t      push_cmd,
  input  logic               pop,
  output rre_pkg::cmd_t      head,
  output rre_pkg::q_stat_t   stat
);

  rre_pkg::cmd_t ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  // Advance pointers and the fill count on each transfer
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= push_cmd;
  end

  assign head          = ent_r[rd_ptr_r];
  assign stat.full     = (cnt_r == 2'd2);
  assign stat.nonempty = (cnt_r != 2'd0);

endmodule

[rtl/rre_back.sv]
// Result stage of the RRE decoder: turns commands into absolute fills.
// Depends on rre_pkg; holds the output register.
module rre_back (
  input  logic               clk,
  input  logic               rst_n,
  input  rre_pkg::cmd_t      head,
  input  rre_pkg::q_stat_t   stat,
  input  rre_pkg::cfg_t      cfg,
  input  logic               out_ready,
  output logic               pop,
  output logic               out_valid,
  output rre_pkg::res_t      res
);

  logic          vld_r, vld_nxt;
  rre_pkg::res_t res_r, res_nxt;
  logic [rre_pkg::COORD_W:0] xl_w, yt_w, xr_w, yb_w;

  // Load a new result when the register is empty or being drained
  assign pop = stat.nonempty && (!vld_r || out_ready);

  always_comb begin
    xl_w = {2'b00, cfg.rect_x} + {2'b00, head.sx};
    yt_w = {2'b00, cfg.rect_y} + {2'b00, head.sy};
    xr_w = xl_w + {2'b00, head.sw};
    yb_w = yt_w + {2'b00, head.sh};
    res_nxt.pix  = head.pix;
    res_nxt.last = head.last;
    res_nxt.err  = 1'b0;
    case (head.kind)
      rre_pkg::CMD_BG: begin
        res_nxt.xl = {1'b0, cfg.rect_x};
        res_nxt.yt = {1'b0, cfg.rect_y};
        res_nxt.xr = {1'b0, cfg.rect_x} + {1'b0, cfg.rect_w};
        res_nxt.yb = {1'b0, cfg.rect_y} + {1'b0, cfg.rect_h};
      end
      rre_pkg::CMD_SUB: begin
        res_nxt.xl = xl_w[rre_pkg::COORD_W-1:0];
        res_nxt.yt = yt_w[rre_pkg::COORD_W-1:0];
        res_nxt.xr = xr_w[rre_pkg::COORD_W-1:0];
        res_nxt.yb = yb_w[rre_pkg::COORD_W-1:0];
      end
      default: begin
        // bounds error: all coordinates and pixel zero
        res_nxt.xl   = '0;
        res_nxt.yt   = '0;
        res_nxt.xr   = '0;
        res_nxt.yb   = '0;
        res_nxt.pix  = '0;
        res_nxt.err  = 1'b1;
        res_nxt.last = 1'b1;
      end
    endcase
    if (pop) vld_nxt = 1'b1;
    else if (out_ready) vld_nxt = 1'b0;
    else vld_nxt = vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= vld_nxt;
  end

  always_ff @(posedge clk) begin
    if (pop) res_r <= res_nxt;
  end

  assign out_valid = vld_r;
  assign res       = res_r;

endmodule

[rtl/rre_rectangle_decoder_top.sv]
// Top level of the RRE rectangle decoder: configuration registers and wiring.
// Depends on rre_pkg, rre_front, rre_queue and rre_back.
//
//   channel  | direction | contents
//   in_*     | input     | tdata: data_byte [7:0]; tuser: start_of_rect
//   out_*    | output    | tdata: fill command (104 bits); tlast: last
//   cfg_*    | input     | register index and 16-bit write data, no read-back
//
// One payload byte is taken every cycle while in_tready is high; a completed
// result is written to the queue, then loaded into the output register.
// Synchronous active-low reset returns the parser to idle and the registers to
// their defaults; there is no clearing pass.
// in_tready falls only while the two-entry command queue is full, which happens
// when out_tready has been low for three result-producing bytes (one waits in
// the output register, two in the queue).
module rre_rectangle_decoder_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [rre_pkg::BYTE_W-1:0]         in_tdata,   // [7:0] data_byte
  input  logic                               in_tuser,   // [0] start_of_rect
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [16:0] x_left, [33:17] y_top, [50:34] x_right, [67:51] y_bottom,
  // [99:68] pixel_value, [100] decode_error, [103:101] zero
  output logic [rre_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                               out_tlast,
  input  logic                               cfg_we,
  input  logic [rre_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rre_pkg::FIELD_W-1:0]        cfg_wdata
);

  rre_pkg::cfg_t    cfg_r, cfg_nxt;
  rre_pkg::cmd_t    push_cmd, head;
  rre_pkg::q_stat_t stat;
  rre_pkg::res_t    res;
  logic             in_accept, push, pop;

  // Register writes; indexes beyond the list are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        rre_pkg::CFG_PSIZE:  cfg_nxt.psize  = cfg_wdata[rre_pkg::PSZ_W-1:0];
        rre_pkg::CFG_RECT_X: cfg_nxt.rect_x = cfg_wdata;
        rre_pkg::CFG_RECT_Y: cfg_nxt.rect_y = cfg_wdata;
        rre_pkg::CFG_RECT_W: cfg_nxt.rect_w = cfg_wdata;
        rre_pkg::CFG_RECT_H: cfg_nxt.rect_h = cfg_wdata;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.psize  <= rre_pkg::PSZ_RESET;
      cfg_r.rect_x <= '0;
      cfg_r.rect_y <= '0;
      cfg_r.rect_w <= '0;
      cfg_r.rect_h <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_tready = !stat.full;
  assign in_accept = in_tvalid && in_tready;

  rre_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_byte   (in_tdata),
    .in_start  (in_tuser),
    .cfg       (cfg_r),
    .push      (push),
    .cmd       (push_cmd)
  );

  rre_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  rre_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .stat      (stat),
    .cfg       (cfg_r),
    .out_ready (out_tready),
    .pop       (pop),
    .out_valid (out_tvalid),
    .res       (res)
  );

  assign out_tdata = {3'b000, res.err, res.pix, res.yb, res.xr, res.yt, res.xl};
  assign out_tlast = res.last;

endmodule

[rtl/rre_checker.sv]
// Port-level assertions for the RRE rectangle decoder, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module rre_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata,
  input logic         out_tlast
);

  // A stalled result holds
  `RRE_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")

  // A bounds error closes the rectangle and carries no fill
  `RRE_ASSERT_IMP(a_err_zero, out_tvalid && out_tdata[100], out_tlast && (out_tdata[99:0] == 100'd0), "error result not empty")

  // Padding above the error flag stays zero
  `RRE_ASSERT_IMP(a_pad_zero, out_tvalid, out_tdata[103:101] == 3'd0, "padding bits set")

  // A good fill never has its far corner before its near corner
  `RRE_ASSERT_IMP(a_corner_order, out_tvalid && !out_tdata[100], (out_tdata[50:34] >= out_tdata[16:0]) && (out_tdata[67:51] >= out_tdata[33:17]), "fill corners out of order")

endmodule

bind rre_rectangle_decoder_top rre_checker u_rre_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
